/* rtl/disjoint_set_union_engine_core_assert.svh */
// Assertion macros used by the checker of the disjoint-set union engine.
// Each macro states one clocked implication with reset as the disable.
`ifndef DISJOINT_SET_UNION_ENGINE_CORE_ASSERT_SVH
`define DISJOINT_SET_UNION_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define DSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsu check failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define DSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsu check failed: next-cycle implication");

`endif

/* rtl/dsu_pkg.sv */
// Shared types and constants of the disjoint-set union engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package dsu_pkg;

  // Default number of elements in the table.
  localparam int ELEMENTS_DEF = 4096;

  // Fixed widths of the word fields.
  localparam int IN_W   = 12;
  localparam int SIZE_W = 13;

  // Largest set size the size table can hold.
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;   // write one reset entry of both tables
    logic latch_in;     // capture the accepted word
    logic sel_y;        // current find works on y rather than x
    logic walk_begin;   // load the walk pointer with the start element
    logic walk_step;    // follow the parent just read
    logic set_top;      // the current node is the root
    logic compress_wr;  // point the current node straight at the root
    logic save_root;    // store the root of the current find
    logic size_rd_y;    // read the size of y's root, capture x's size
    logic finish;       // link if needed and present the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;   // clearing pass is at its last entry
    logic node_is_root; // parent just read equals the node itself
    logic node_at_top;  // second walk has reached the root
  } dp_sts_t;

endpackage

/* rtl/dsu_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the parent and size tables.
module dsu_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write when enabled; read every cycle with the data registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/dsu_ctrl.sv */
// Controller state machine of the disjoint-set union engine.
// Depends on dsu_pkg for the command and status structs.
module dsu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dsu_pkg::dp_sts_t  sts,
  output dsu_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_W1_BEGIN = 4'd2;
  localparam logic [3:0] S_W1       = 4'd3;
  localparam logic [3:0] S_W2_BEGIN = 4'd4;
  localparam logic [3:0] S_W2       = 4'd5;
  localparam logic [3:0] S_SZ_X     = 4'd6;
  localparam logic [3:0] S_SZ_Y     = 4'd7;
  localparam logic [3:0] S_UPD      = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       sel_y_r, sel_y_nxt;

  // State and find selector registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sel_y_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_y_r <= sel_y_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    sel_y_nxt = sel_y_r;
    cmd       = '0;
    cmd.sel_y = sel_y_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          sel_y_nxt    = 1'b0;
          state_nxt    = S_W1_BEGIN;
        end
      end
      S_W1_BEGIN: begin
        cmd.walk_begin = 1'b1;
        state_nxt      = S_W1;
      end
      S_W1: begin
        if (sts.node_is_root) begin
          cmd.set_top = 1'b1;
          state_nxt   = S_W2_BEGIN;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_W2_BEGIN: begin
        cmd.walk_begin = 1'b1;
        state_nxt      = S_W2;
      end
      S_W2: begin
        if (sts.node_at_top) begin
          cmd.save_root = 1'b1;
          if (sel_y_r) begin
            state_nxt = S_SZ_X;
          end else begin
            sel_y_nxt = 1'b1;
            state_nxt = S_W1_BEGIN;
          end
        end else begin
          cmd.compress_wr = 1'b1;
          cmd.walk_step   = 1'b1;
        end
      end
      S_SZ_X: begin
        state_nxt = S_SZ_Y;
      end
      S_SZ_Y: begin
        cmd.size_rd_y = 1'b1;
        state_nxt     = S_UPD;
      end
      S_UPD: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dsu_datapath.sv */
// Datapath of the disjoint-set union engine: parent and size tables, walk
// pointers, size arithmetic and result registers. Depends on dsu_pkg, dsu_ram.
module dsu_datapath #(
  parameter int ELEMENTS = dsu_pkg::ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dsu_pkg::dp_cmd_t                cmd,
  output dsu_pkg::dp_sts_t                sts,
  input  logic                            in_command,
  input  logic [dsu_pkg::IN_W-1:0]        in_elem_x,
  input  logic [dsu_pkg::IN_W-1:0]        in_elem_y,
  output logic                            out_valid,
  output logic [dsu_pkg::IN_W-1:0]        out_root_of_x,
  output logic [dsu_pkg::IN_W-1:0]        out_root_of_y,
  output logic                            out_already_joined,
  output logic [dsu_pkg::SIZE_W-1:0]      out_set_size_x
);

  localparam int IDX_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int CMP_W = ((IDX_W > dsu_pkg::IN_W) ? IDX_W : dsu_pkg::IN_W) + 1;
  localparam logic [CMP_W-1:0] ELEM_LAST = CMP_W'(ELEMENTS - 1);
  localparam int SW = dsu_pkg::SIZE_W;

  // Input clamp: an index beyond the table maps to the last element.
  logic [CMP_W-1:0] x_ext, y_ext;
  logic [IDX_W-1:0] x_idx, y_idx;

  assign x_ext = CMP_W'(in_elem_x);
  assign y_ext = CMP_W'(in_elem_y);
  assign x_idx = (x_ext > ELEM_LAST) ? ELEM_LAST[IDX_W-1:0] : x_ext[IDX_W-1:0];
  assign y_idx = (y_ext > ELEM_LAST) ? ELEM_LAST[IDX_W-1:0] : y_ext[IDX_W-1:0];

  logic             cmd_r;
  logic [IDX_W-1:0] x_r, y_r, node_r, top_r, rx_r, ry_r, clr_r;
  logic [SW-1:0]    sx_r;
  logic             out_valid_r, out_joined_r;
  logic [dsu_pkg::IN_W-1:0] out_rx_r, out_ry_r;
  logic [SW-1:0]    out_sx_r;

  logic [IDX_W-1:0] start_idx, par_raddr, par_rdata, par_waddr, par_wdata;
  logic             par_we;
  logic [IDX_W-1:0] size_raddr, size_waddr;
  logic [SW-1:0]    size_rdata, size_wdata, sum_sat;
  logic [SW:0]      sum;
  logic             size_we, joined, link;

  // Walk addressing: start of the current find, else follow the parent read.
  assign start_idx = cmd.sel_y ? y_r : x_r;
  assign par_raddr = cmd.walk_begin ? start_idx : par_rdata;

  // Size arithmetic with saturation.
  assign joined  = (rx_r == ry_r);
  assign link    = cmd_r && !joined;
  assign sum     = {1'b0, sx_r} + {1'b0, size_rdata};
  assign sum_sat = (sum > {1'b0, dsu_pkg::SIZE_MAX}) ? dsu_pkg::SIZE_MAX : sum[SW-1:0];

  // Parent table writes: clearing, path compression, or linking x's root.
  assign par_we    = cmd.clear_step || cmd.compress_wr || (cmd.finish && link);
  assign par_waddr = cmd.clear_step ? clr_r : (cmd.compress_wr ? node_r : rx_r);
  assign par_wdata = cmd.clear_step ? clr_r : (cmd.compress_wr ? top_r : ry_r);

  // Size table writes: clearing, or the merged size at y's root.
  assign size_raddr = cmd.size_rd_y ? ry_r : rx_r;
  assign size_we    = cmd.clear_step || (cmd.finish && link);
  assign size_waddr = cmd.clear_step ? clr_r : ry_r;
  assign size_wdata = cmd.clear_step ? SW'(1) : sum_sat;

  dsu_ram #(.WIDTH(IDX_W), .DEPTH(ELEMENTS)) u_parent (
    .clk     (clk),
    .wr_en   (par_we),
    .wr_addr (par_waddr),
    .wr_data (par_wdata),
    .rd_addr (par_raddr),
    .rd_data (par_rdata)
  );

  dsu_ram #(.WIDTH(SW), .DEPTH(ELEMENTS)) u_size (
    .clk     (clk),
    .wr_en   (size_we),
    .wr_addr (size_waddr),
    .wr_data (size_wdata),
    .rd_addr (size_raddr),
    .rd_data (size_rdata)
  );

  // Status for the controller.
  assign sts.clear_last   = (clr_r == IDX_W'(ELEMENTS - 1));
  assign sts.node_is_root = (par_rdata == node_r);
  assign sts.node_at_top  = (node_r == top_r);

  // Control registers: clearing counter and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      out_valid_r <= cmd.finish;
    end
  end

  // Payload registers: accepted word, walk pointers, roots and sizes.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_command;
      x_r   <= x_idx;
      y_r   <= y_idx;
    end
    if (cmd.walk_begin) begin
      node_r <= start_idx;
    end else if (cmd.walk_step) begin
      node_r <= par_rdata;
    end
    if (cmd.set_top) begin
      top_r <= node_r;
    end
    if (cmd.save_root) begin
      if (cmd.sel_y) begin
        ry_r <= top_r;
      end else begin
        rx_r <= top_r;
      end
    end
    if (cmd.size_rd_y) begin
      sx_r <= size_rdata;
    end
    if (cmd.finish) begin
      out_rx_r     <= dsu_pkg::IN_W'(link ? ry_r : rx_r);
      out_ry_r     <= dsu_pkg::IN_W'(ry_r);
      out_joined_r <= joined;
      out_sx_r     <= link ? sum_sat : sx_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_root_of_x      = out_rx_r;
  assign out_root_of_y      = out_ry_r;
  assign out_already_joined = out_joined_r;
  assign out_set_size_x     = out_sx_r;

endmodule

/* rtl/disjoint_set_union_engine_core.sv */
// Top level of the disjoint-set union engine (union-find, full path compression).
// Depends on dsu_pkg, dsu_ctrl, dsu_datapath and dsu_ram.
//
// Usage:
//   Input word: in_command (0 query, 1 unite x into y), in_elem_x, in_elem_y.
//   A word is taken at a rising edge with start high and busy low. Indexes
//   beyond the table read as the last element.
//   Result word: out_root_of_x, out_root_of_y, out_already_joined and
//   out_set_size_x, shown for one cycle with out_valid high. The receiver
//   cannot stall; it must take the word in that cycle.
//   Each find walks the parent chain once to the root and once more to
//   compress it, one hop per cycle through the single read port of the
//   parent memory; the size lookups and the link follow. busy drops in
//   the cycle out_valid rises, so the next word can follow at once.
//   Reset: after rst_n is released, a clearing pass of ELEMENTS cycles writes
//   every parent to itself and every size to one; busy stays high meanwhile.
module disjoint_set_union_engine_core #(
  parameter int ELEMENTS = dsu_pkg::ELEMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [dsu_pkg::IN_W-1:0]    in_elem_x,
  input  logic [dsu_pkg::IN_W-1:0]    in_elem_y,
  output logic                        out_valid,
  output logic [dsu_pkg::IN_W-1:0]    out_root_of_x,
  output logic [dsu_pkg::IN_W-1:0]    out_root_of_y,
  output logic                        out_already_joined,
  output logic [dsu_pkg::SIZE_W-1:0]  out_set_size_x
);

  dsu_pkg::dp_cmd_t dp_cmd;
  dsu_pkg::dp_sts_t dp_sts;

  dsu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (dp_sts),
    .cmd   (dp_cmd)
  );

  dsu_datapath #(.ELEMENTS(ELEMENTS)) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .sts                (dp_sts),
    .in_command         (in_command),
    .in_elem_x          (in_elem_x),
    .in_elem_y          (in_elem_y),
    .out_valid          (out_valid),
    .out_root_of_x      (out_root_of_x),
    .out_root_of_y      (out_root_of_y),
    .out_already_joined (out_already_joined),
    .out_set_size_x     (out_set_size_x)
  );

endmodule

/* rtl/dsu_checker.sv */
// Port-level checker of the disjoint-set union engine, bound to the top level.
// Depends on dsu_pkg and the assertion macro header.
`include "disjoint_set_union_engine_core_assert.svh"

module dsu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [dsu_pkg::IN_W-1:0]    out_root_of_x,
  input logic [dsu_pkg::IN_W-1:0]    out_root_of_y,
  input logic                        out_already_joined,
  input logic [dsu_pkg::SIZE_W-1:0]  out_set_size_x
);

  // An accepted word keeps the block busy in the next cycle.
  `DSU_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // A result only ends a busy period and lasts a single cycle.
  `DSU_ASSERT_SAME(a_result_after_busy, clk, rst_n, out_valid, $past(busy))
  `DSU_ASSERT_NEXT(a_result_pulse, clk, rst_n, out_valid, !out_valid)

  // Joined elements report one root, and a set is never empty.
  `DSU_ASSERT_SAME(a_joined_roots, clk, rst_n, out_valid && out_already_joined,
                   out_root_of_x == out_root_of_y)
  `DSU_ASSERT_SAME(a_size_nonzero, clk, rst_n, out_valid, out_set_size_x != '0)

endmodule

bind disjoint_set_union_engine_core dsu_checker u_dsu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_root_of_x      (out_root_of_x),
  .out_root_of_y      (out_root_of_y),
  .out_already_joined (out_already_joined),
  .out_set_size_x     (out_set_size_x)
);

/* tb/disjoint_set_union_engine_core_test.sv */
// Self-checking testbench for the disjoint-set union engine core.
// A scoreboard class keeps its own union-find tables and predicts every result word.
// Depends on dsu_pkg and disjoint_set_union_engine_core only.
`timescale 1ns / 100ps

module disjoint_set_union_engine_core_test;

  localparam int IN_W   = dsu_pkg::IN_W;
  localparam int SIZE_W = dsu_pkg::SIZE_W;
  localparam logic [SIZE_W-1:0] SIZE_MAX = dsu_pkg::SIZE_MAX;

  localparam int TABLE_ELEMS   = dsu_pkg::ELEMENTS_DEF;
  localparam int RANDOM_WORDS  = 750;
  localparam int IDLE_LIMIT    = 65536;
  localparam int TAIL_CYCLES   = 32;
  localparam int RESET_CYCLES  = 7;

  // Command codes of the input word.
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_UNITE = 1'b1;

  typedef struct {
    logic [IN_W-1:0]   root_x;
    logic [IN_W-1:0]   root_y;
    logic              joined;
    logic [SIZE_W-1:0] size_x;
  } dsu_result_t;

  // Scoreboard: mirrors the parent and size tables and queues predicted words.
  class dsu_scoreboard;
    logic [IN_W-1:0]   parent_tab [TABLE_ELEMS];
    logic [SIZE_W-1:0] size_tab   [TABLE_ELEMS];
    dsu_result_t       pending_q  [$];
    int                errors;
    int                checked;

    function new();
      for (int i = 0; i < TABLE_ELEMS; i++) begin
        parent_tab[i] = IN_W'(i);
        size_tab[i]   = SIZE_W'(1);
      end
      errors  = 0;
      checked = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Indexes past the end of the table read as the last element.
    function int clamp_elem(logic [IN_W-1:0] v);
      if (int'(v) >= TABLE_ELEMS) return TABLE_ELEMS - 1;
      return int'(v);
    endfunction

    // Walk to the root, then walk again and point every node on the path at it.
    function int find_and_compress(int first);
      int node;
      int top;
      int up;
      int guard;
      node  = first;
      guard = 0;
      while (guard < TABLE_ELEMS) begin
        up = int'(parent_tab[node]);
        if (up == node) break;
        node = up % TABLE_ELEMS;
        guard++;
      end
      top   = node;
      node  = first;
      guard = 0;
      while (guard < TABLE_ELEMS && node != top) begin
        up = int'(parent_tab[node]) % TABLE_ELEMS;
        parent_tab[node] = IN_W'(top);
        node = up;
        guard++;
      end
      return top;
    endfunction

    // Note an accepted input word and predict its result word.
    function void note_word(logic cmd, logic [IN_W-1:0] ex, logic [IN_W-1:0] ey);
      int              rx;
      int              ry;
      logic [SIZE_W:0] sum;
      logic [SIZE_W-1:0] sx;
      logic [SIZE_W-1:0] sy;
      dsu_result_t     res;
      rx = find_and_compress(clamp_elem(ex));
      ry = find_and_compress(clamp_elem(ey));
      sx = size_tab[rx];
      sy = size_tab[ry];
      res.joined = (rx == ry);
      if (cmd == CMD_UNITE && !res.joined) begin
        sum = {1'b0, sx} + {1'b0, sy};
        if (sum > {1'b0, SIZE_MAX}) sum = {1'b0, SIZE_MAX};
        parent_tab[rx] = IN_W'(ry);
        size_tab[ry]   = sum[SIZE_W-1:0];
        rx = ry;
        sx = sum[SIZE_W-1:0];
      end
      res.root_x = IN_W'(rx);
      res.root_y = IN_W'(ry);
      res.size_x = sx;
      pending_q = {pending_q, res};
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch at result %0d: %s got %0d, want %0d", checked, what, got, want);
    endtask

    // Compare one result word with the oldest prediction.
    task check_word(logic [IN_W-1:0] rx, logic [IN_W-1:0] ry, logic joined,
                    logic [SIZE_W-1:0] sx);
      dsu_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result word, root_of_x", int'(rx), -1);
      end else begin
        want = pending_q.pop_front();
        if (rx !== want.root_x) report_mismatch("root_of_x", int'(rx), int'(want.root_x));
        if (ry !== want.root_y) report_mismatch("root_of_y", int'(ry), int'(want.root_y));
        if (joined !== want.joined)
          report_mismatch("already_joined", int'(joined), int'(want.joined));
        if (sx !== want.size_x) report_mismatch("set_size_x", int'(sx), int'(want.size_x));
      end
      checked++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_command = CMD_QUERY;
  logic [IN_W-1:0]   in_elem_x = '0;
  logic [IN_W-1:0]   in_elem_y = '0;
  logic              out_valid;
  logic [IN_W-1:0]   out_root_of_x;
  logic [IN_W-1:0]   out_root_of_y;
  logic              out_already_joined;
  logic [SIZE_W-1:0] out_set_size_x;

  dsu_scoreboard sb = new();
  bit            calm = 1'b0;
  int            words_sent = 0;
  int            idle_cycles = 0;

  disjoint_set_union_engine_core #(.ELEMENTS(TABLE_ELEMS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_elem_x          (in_elem_x),
    .in_elem_y          (in_elem_y),
    .out_valid          (out_valid),
    .out_root_of_x      (out_root_of_x),
    .out_root_of_y      (out_root_of_y),
    .out_already_joined (out_already_joined),
    .out_set_size_x     (out_set_size_x)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every result word is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_word(out_root_of_x, out_root_of_y, out_already_joined, out_set_size_x);
    end
  end

  // Watchdog: ends the run after too many cycles with no word accepted and no result.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL disjoint_set_union_engine_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one input word after a random gap (none in calm blocks) and wait until it is taken.
  task automatic send_word(logic cmd, logic [IN_W-1:0] ex, logic [IN_W-1:0] ey);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_elem_x  <= ex;
    in_elem_y  <= ey;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_word(cmd, ex, ey);
    words_sent++;
  endtask

  // Hold the sender off until every predicted word has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Build a chain a -> a+1 -> ... by uniting neighbors, then query its ends.
  task automatic chain_burst(int base, int len);
    for (int i = 0; i < len; i++) begin
      send_word(CMD_UNITE, IN_W'(base + i), IN_W'(base + i + 1));
    end
    send_word(CMD_QUERY, IN_W'(base), IN_W'(base + len));
  endtask

  task automatic random_word(int window_base);
    int   pick;
    logic cmd;
    logic [IN_W-1:0] ex;
    logic [IN_W-1:0] ey;
    pick = $urandom_range(0, 99);
    cmd  = ($urandom_range(0, 9) < 6) ? CMD_UNITE : CMD_QUERY;
    if (pick < 7) begin
      pick = $urandom_range(3, 30);
      chain_burst($urandom_range(0, TABLE_ELEMS - 2 - pick), pick);
    end else begin
      if (pick < 60) begin
        ex = IN_W'(window_base + $urandom_range(0, 31));
        ey = IN_W'(window_base + $urandom_range(0, 31));
      end else if (pick < 80) begin
        ex = IN_W'($urandom_range(0, 255));
        ey = IN_W'($urandom_range(0, 255));
      end else begin
        ex = IN_W'($urandom_range(0, 4095));
        ey = IN_W'($urandom_range(0, 4095));
        cmd = logic'($urandom_range(0, 1));
      end
      send_word(cmd, ex, ey);
    end
  endtask

  initial begin
    int window_base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: field extremes, both commands, self unite, rejoin, chains.
    send_word(CMD_QUERY, 12'h000, 12'h000);
    send_word(CMD_QUERY, 12'hFFF, 12'hFFF);
    send_word(CMD_QUERY, 12'h000, 12'hFFF);
    send_word(CMD_UNITE, 12'h000, 12'hFFF);
    send_word(CMD_UNITE, 12'h000, 12'hFFF);
    send_word(CMD_UNITE, 12'hFFF, 12'h000);
    send_word(CMD_UNITE, 12'h007, 12'h007);
    send_word(CMD_UNITE, 12'hAAA, 12'h555);
    send_word(CMD_QUERY, 12'h555, 12'hAAA);
    chain_burst(1, 4);
    send_word(CMD_QUERY, 12'h001, 12'h001);
    send_word(CMD_UNITE, 12'h005, 12'h000);
    send_word(CMD_QUERY, 12'h002, 12'hFFF);
    send_word(CMD_UNITE, 12'h555, 12'h003);
    send_word(CMD_QUERY, 12'hAAA, 12'h001);
    send_word(CMD_UNITE, 12'hAAA, 12'h004);
    drain_results();

    // Random words in blocks; some blocks run with no gaps, some end drained.
    while (words_sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      window_base = $urandom_range(0, TABLE_ELEMS - 32);
      for (int k = 0; k < 40; k++) begin
        random_word(window_base);
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS disjoint_set_union_engine_core");
    end else begin
      $display("FAIL disjoint_set_union_engine_core");
    end
    $finish;
  end

endmodule
